// ===== rtl/arr_pkg.sv =====
// Shared constants, codes and types of the aspect ratio reducer.
`default_nettype none

package arr_pkg;

	localparam int DIM_BITS     = 16;
	localparam int CNT_BITS     = $clog2(DIM_BITS + 1);
	localparam int TWOS_BITS    = $clog2(DIM_BITS);
	localparam int S_TDATA_BITS = ((2 * DIM_BITS + 7) / 8) * 8;
	localparam int M_TDATA_BITS = ((3 * DIM_BITS + 7) / 8) * 8;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

	// item classes
	localparam logic [1:0] KIND_GEN   = 2'd0;
	localparam logic [1:0] KIND_WZERO = 2'd1;
	localparam logic [1:0] KIND_HZERO = 2'd2;
	localparam logic [1:0] KIND_BOTH  = 2'd3;

	typedef struct packed {
		logic [1:0]          kind;
		logic [DIM_BITS-1:0] w;
		logic [DIM_BITS-1:0] h;
	} arr_job_t;

	typedef struct packed {
		logic [DIM_BITS-1:0] ratio_width;
		logic [DIM_BITS-1:0] ratio_height;
		logic [DIM_BITS-1:0] common_divisor;
		logic                undefined_ratio;
	} arr_res_t;

endpackage

`default_nettype wire

// ===== rtl/arr_front.sv =====
// Input side: takes items, splits the fields and classifies the zero cases.
`default_nettype none

module arr_front import arr_pkg::*; (
	input  wire logic                    s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire logic [S_TDATA_BITS-1:0] s_axis_tdata,  // width, height
	output logic                         push,
	output arr_job_t                     job,
	input  wire logic                    queue_full
);

	logic [DIM_BITS-1:0] w;
	logic [DIM_BITS-1:0] h;

	assign w             = s_axis_tdata[DIM_BITS-1:0];
	assign h             = s_axis_tdata[2*DIM_BITS-1:DIM_BITS];
	assign s_axis_tready = !queue_full;
	assign push          = s_axis_tvalid && !queue_full;

	always_comb begin
		job.w = w;
		job.h = h;
		if (w == '0 && h == '0) begin
			job.kind = KIND_BOTH;
		end else if (w == '0) begin
			job.kind = KIND_WZERO;
		end else if (h == '0) begin
			job.kind = KIND_HZERO;
		end else begin
			job.kind = KIND_GEN;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/arr_queue.sv =====
// Short job queue between the input side and the reduction engine.
`default_nettype none

module arr_queue import arr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire arr_job_t push_job,
	output logic          full,
	input  wire logic     pop,
	output logic          pop_valid,
	output arr_job_t      pop_job
);

	arr_job_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full      = count_q == QCNT_BITS'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_job   = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/arr_back.sv =====
// Reduction engine: binary GCD one step a cycle, then two bit-serial divides.
`default_nettype none

module arr_back import arr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     job_valid,
	input  wire arr_job_t job,
	output logic          job_pop,
	output logic          out_valid,
	input  wire logic     out_ready,
	output arr_res_t      out_res
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TWOS = 3'd1;
	localparam logic [2:0] ST_AODD = 3'd2;
	localparam logic [2:0] ST_LOOP = 3'd3;
	localparam logic [2:0] ST_DIVW = 3'd4;
	localparam logic [2:0] ST_DIVH = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]           state_q;
	logic                 out_valid_q;
	arr_res_t             out_q;
	logic [DIM_BITS-1:0]  w_q;
	logic [DIM_BITS-1:0]  h_q;
	logic [DIM_BITS-1:0]  a_q;
	logic [DIM_BITS-1:0]  b_q;
	logic [TWOS_BITS-1:0] twos_q;
	logic [DIM_BITS-1:0]  g_q;
	logic [DIM_BITS-1:0]  rw_q;
	logic [DIM_BITS-1:0]  rh_q;
	logic                 undef_q;
	logic [DIM_BITS-1:0]  num_q;
	logic [DIM_BITS-1:0]  rem_q;
	logic [CNT_BITS-1:0]  cnt_q;

	logic                 twos_done;
	logic                 a_gt_b;
	logic [DIM_BITS-1:0]  a_new;
	logic [DIM_BITS-1:0]  b_new;
	logic                 loop_end;
	logic [DIM_BITS:0]    rem_sh;
	logic                 q_bit;
	logic [DIM_BITS-1:0]  rem_next;
	logic [DIM_BITS-1:0]  quot_next;
	logic                 div_last;
	logic                 out_free;

	assign twos_done = a_q[0] || b_q[0];
	assign a_gt_b    = a_q > b_q;
	assign a_new     = a_gt_b ? b_q : a_q;
	assign b_new     = a_gt_b ? (a_q - b_q) : (b_q - a_q);
	assign loop_end  = b_q[0] && b_new == '0;

	assign rem_sh    = {rem_q, num_q[DIM_BITS-1]};
	assign q_bit     = rem_sh >= {1'b0, g_q};
	assign rem_next  = q_bit ? DIM_BITS'(rem_sh - {1'b0, g_q}) : rem_sh[DIM_BITS-1:0];
	assign quot_next = {num_q[DIM_BITS-2:0], q_bit};
	assign div_last  = cnt_q == CNT_BITS'(DIM_BITS - 1);

	assign out_free  = !out_valid_q || out_ready;
	assign job_pop   = state_q == ST_IDLE && job_valid;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= (job.kind == KIND_GEN) ? ST_TWOS : ST_DONE;
					end
				end
				ST_TWOS: begin
					if (twos_done) begin
						state_q <= ST_AODD;
					end
				end
				ST_AODD: begin
					if (a_q[0]) begin
						state_q <= ST_LOOP;
					end
				end
				ST_LOOP: begin
					if (loop_end) begin
						state_q <= ST_DIVW;
					end
				end
				ST_DIVW: begin
					if (div_last) begin
						state_q <= ST_DIVH;
					end
				end
				ST_DIVH: begin
					if (div_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					w_q     <= job.w;
					h_q     <= job.h;
					a_q     <= job.w;
					b_q     <= job.h;
					twos_q  <= '0;
					undef_q <= job.kind == KIND_BOTH;
					case (job.kind)
						KIND_BOTH: begin
							rw_q <= '0;
							rh_q <= '0;
							g_q  <= '0;
						end
						KIND_WZERO: begin
							rw_q <= '0;
							rh_q <= DIM_BITS'(1);
							g_q  <= job.h;
						end
						KIND_HZERO: begin
							rw_q <= DIM_BITS'(1);
							rh_q <= '0;
							g_q  <= job.w;
						end
						default: begin
							rw_q <= '0;
							rh_q <= '0;
							g_q  <= '0;
						end
					endcase
				end
			end
			ST_TWOS: begin
				if (!twos_done) begin
					a_q    <= a_q >> 1;
					b_q    <= b_q >> 1;
					twos_q <= twos_q + TWOS_BITS'(1);
				end
			end
			ST_AODD: begin
				if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end
			end
			ST_LOOP: begin
				if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else begin
					a_q <= a_new;
					b_q <= b_new;
					if (b_new == '0) begin
						g_q   <= a_new << twos_q;
						num_q <= w_q;
						rem_q <= '0;
						cnt_q <= '0;
					end
				end
			end
			ST_DIVW, ST_DIVH: begin
				if (div_last) begin
					if (state_q == ST_DIVW) begin
						rw_q <= quot_next;
					end else begin
						rh_q <= quot_next;
					end
					num_q <= h_q;
					rem_q <= '0;
					cnt_q <= '0;
				end else begin
					num_q <= quot_next;
					rem_q <= rem_next;
					cnt_q <= cnt_q + CNT_BITS'(1);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_q.ratio_width     <= rw_q;
					out_q.ratio_height    <= rh_q;
					out_q.common_divisor  <= g_q;
					out_q.undefined_ratio <= undef_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.undefined_ratio |->
			out_q.ratio_width == '0 && out_q.ratio_height == '0 &&
			out_q.common_divisor == '0)
		else $error("undefined result carries nonzero fields");

	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.undefined_ratio |-> out_q.common_divisor != '0)
		else $error("defined result with zero divisor");

	a_loop_a_odd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOOP |-> a_q[0])
		else $error("even operand in subtract loop");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVW || state_q == ST_DIVH) |-> g_q != '0)
		else $error("divide by zero divisor");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside completion");

endmodule

`default_nettype wire

// ===== rtl/aspect_ratio_reducer_unit.sv =====
// Aspect ratio reducer: reduces a width:height pair to lowest terms.
//
// Input stream s_axis carries width (low half) and height (high half).
// Output stream m_axis carries ratio_width, ratio_height and common_divisor
// in tdata, lowest first; tuser is the undefined flag (both inputs zero,
// all data fields zero).
// Items are queued (two entries) in front of a single reduction engine and
// handled one at a time, in order. The engine finds the divisor with a
// binary GCD, one shift or subtract per cycle, then divides each dimension
// with a restoring divider, one quotient bit per cycle.
// For two nonzero inputs the GCD runs its steps in order (shared twos, odd
// alignment, subtract loop) before the divides; a zero input skips them all.
// The engine's GCD and divide sequence sets the throughput: it takes no new
// item until it is done with the current one.
// Reset clears the queue and the engine; no item is lost afterwards. When the
// receiver stalls the result holds in the output register; the engine starts
// the next item and waits with it once finished, and s_axis_tready falls when
// the queue is full.
`default_nettype none

module aspect_ratio_reducer_unit import arr_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire logic [S_TDATA_BITS-1:0] s_axis_tdata,  // width, height
	output logic                         m_axis_tvalid,
	input  wire logic                    m_axis_tready,
	output logic [M_TDATA_BITS-1:0]      m_axis_tdata,  // ratio_width, ratio_height, common_divisor
	output logic                         m_axis_tuser   // undefined_ratio
);

	logic     push;
	arr_job_t push_job;
	logic     queue_full;
	logic     pop;
	logic     pop_valid;
	arr_job_t pop_job;
	arr_res_t res;

	arr_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.push          (push),
		.job           (push_job),
		.queue_full    (queue_full)
	);

	arr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (queue_full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_job   (pop_job)
	);

	arr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job       (pop_job),
		.job_pop   (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = M_TDATA_BITS'({res.common_divisor, res.ratio_height, res.ratio_width});
	assign m_axis_tuser = res.undefined_ratio;

endmodule

`default_nettype wire
